// File: design/streaming_source_assembler_unit_defines.svh
// Assertion macros shared by the checker file of the assembler unit.
`ifndef STREAMING_SOURCE_ASSEMBLER_UNIT_DEFINES_SVH
`define STREAMING_SOURCE_ASSEMBLER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define SSA_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SSA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/ssa_pkg.sv
`timescale 1ns / 1ps

package ssa_pkg;

   // Argument expected after the last mnemonic
   localparam logic [1:0] ARG_NONE  = 2'd0;
   localparam logic [1:0] ARG_PUSH  = 2'd1;
   localparam logic [1:0] ARG_BYTES = 2'd2;

   // Error codes carried on the result channel
   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_UNKNOWN  = 2'd1;
   localparam logic [1:0] ERR_ARG_TYPE = 2'd2;
   localparam logic [1:0] ERR_MISSING  = 2'd3;

   // Mnemonic slots
   localparam logic [1:0] MN_SYSCALL = 2'd0;
   localparam logic [1:0] MN_ADD32   = 2'd1;
   localparam logic [1:0] MN_PUSH    = 2'd2;
   localparam logic [1:0] MN_BYTES   = 2'd3;

   // Opcodes
   localparam logic [7:0] OP_SYSCALL = 8'h00;
   localparam logic [7:0] OP_ADD32   = 8'h0c;
   localparam logic [7:0] OP_PUSH    = 8'h03;

   // Characters with a meaning to the parser
   localparam logic [7:0] CHAR_SPACE     = 8'h20;
   localparam logic [7:0] CHAR_NEWLINE   = 8'h0a;
   localparam logic [7:0] CHAR_SEMICOLON = 8'h3b;
   localparam logic [7:0] CHAR_QUOTE     = 8'h22;
   localparam logic [7:0] CHAR_ZERO      = 8'h30;
   localparam logic [7:0] CHAR_NINE      = 8'h39;

   localparam int unsigned POS_WIDTH = 4;
   localparam int unsigned MAX_RESULTS = 4;

   // Mnemonic spelling and length, indexed by slot
   localparam logic [7:0] MN_TEXT [4][8] = '{
      '{8'h73, 8'h79, 8'h73, 8'h63, 8'h61, 8'h6c, 8'h6c, 8'h00},
      '{8'h75, 8'h69, 8'h33, 8'h32, 8'h5f, 8'h61, 8'h64, 8'h64},
      '{8'h70, 8'h75, 8'h73, 8'h68, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h62, 8'h79, 8'h74, 8'h65, 8'h73, 8'h00, 8'h00, 8'h00}
   };
   localparam logic [POS_WIDTH-1:0] MN_LEN [4] = '{4'd7, 4'd8, 4'd4, 4'd5};

   typedef struct packed {
      logic                 in_string;
      logic                 in_comment;
      logic                 in_word;
      logic                 word_is_number;
      logic                 number_stopped;
      logic [POS_WIDTH-1:0] word_position;
      logic [3:0]           mnemonic_candidates;
      logic [31:0]          number_value;
      logic [1:0]           pending_argument;
      logic                 halted;
   } parse_state_type;

   localparam parse_state_type PARSE_RESET = '{
      in_string:           1'b0,
      in_comment:          1'b0,
      in_word:             1'b0,
      word_is_number:      1'b0,
      number_stopped:      1'b0,
      word_position:       '0,
      mnemonic_candidates: 4'hf,
      number_value:        32'd0,
      pending_argument:    ARG_NONE,
      halted:              1'b0
   };

   // Results of one source byte, in delivery order
   typedef struct packed {
      logic [2:0]                        count;
      logic [MAX_RESULTS-1:0][7:0]       code;
      logic [MAX_RESULTS-1:0][1:0]       err;
   } rsp_set_type;

   // Load request from the parser into the result buffer
   typedef struct packed {
      logic        valid;
      rsp_set_type set;
   } buf_load_type;

endpackage

// File: design/ssa_channel_if.sv
`timescale 1ns / 1ps

// Source text channel
interface ssa_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] source_byte;
   logic       end_of_source;

   modport source (output valid, output source_byte, output end_of_source, input ready);
   modport sink (input valid, input source_byte, input end_of_source, output ready);
endinterface

// Bytecode result channel
interface ssa_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] code_byte;
   logic [1:0] error_code;
   logic       run_last;

   modport source (output valid, output code_byte, output error_code, output run_last,
                   input ready);
   modport sink (input valid, input code_byte, input error_code, input run_last,
                 output ready);
endinterface

// File: design/ssa_parse.sv
`timescale 1ns / 1ps

module ssa_parse #(
   parameter int unsigned MAX_MNEMONIC_LENGTH = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic [7:0]           source_byte,
   input  logic                 end_of_source,
   output ssa_pkg::rsp_set_type rsp_set
);

   typedef struct packed {
      ssa_pkg::parse_state_type st;
      ssa_pkg::rsp_set_type     rs;
   } work_type;

   localparam logic [ssa_pkg::POS_WIDTH-1:0] MAX_LEN = ssa_pkg::POS_WIDTH'(MAX_MNEMONIC_LENGTH);

   ssa_pkg::parse_state_type state_ff, state_in;
   work_type                 work;
   logic                     is_digit;
   logic                     is_separator;

   // Append one result, dropping anything past the fourth
   function automatic ssa_pkg::rsp_set_type put_result(ssa_pkg::rsp_set_type r,
                                                       logic [7:0] b, logic [1:0] e);
      ssa_pkg::rsp_set_type o;
      o = r;
      if (r.count < 3'(ssa_pkg::MAX_RESULTS)) begin
         o.code[r.count[1:0]] = b;
         o.err[r.count[1:0]]  = e;
         o.count              = r.count + 3'd1;
      end
      return o;
   endfunction

   // Close the current word: emit push argument or classify a mnemonic
   function automatic work_type finish_word(work_type w);
      work_type   o;
      logic [1:0] pend;
      logic [1:0] hit;
      logic       found;
      o     = w;
      pend  = w.st.pending_argument;
      hit   = ssa_pkg::MN_SYSCALL;
      found = 1'b0;
      o.st.in_word          = 1'b0;
      o.st.pending_argument = ssa_pkg::ARG_NONE;
      if (pend == ssa_pkg::ARG_PUSH) begin
         o.rs = put_result(o.rs, w.st.number_value[31:24], ssa_pkg::ERR_NONE);
         o.rs = put_result(o.rs, w.st.number_value[23:16], ssa_pkg::ERR_NONE);
         o.rs = put_result(o.rs, w.st.number_value[15:8], ssa_pkg::ERR_NONE);
         o.rs = put_result(o.rs, w.st.number_value[7:0], ssa_pkg::ERR_NONE);
      end else if (pend != ssa_pkg::ARG_BYTES && !w.st.word_is_number) begin
         for (int k = 0; k < 4; k++) begin
            if (w.st.mnemonic_candidates[k] && w.st.word_position == ssa_pkg::MN_LEN[k]) begin
               found = 1'b1;
               hit   = 2'(k);
            end
         end
         if (!found) begin
            o.rs        = put_result(o.rs, 8'h00, ssa_pkg::ERR_UNKNOWN);
            o.st.halted = 1'b1;
         end else begin
            case (hit)
               ssa_pkg::MN_SYSCALL: o.rs = put_result(o.rs, ssa_pkg::OP_SYSCALL, ssa_pkg::ERR_NONE);
               ssa_pkg::MN_ADD32:   o.rs = put_result(o.rs, ssa_pkg::OP_ADD32, ssa_pkg::ERR_NONE);
               ssa_pkg::MN_PUSH: begin
                  o.rs = put_result(o.rs, ssa_pkg::OP_PUSH, ssa_pkg::ERR_NONE);
                  o.st.pending_argument = ssa_pkg::ARG_PUSH;
               end
               default: o.st.pending_argument = ssa_pkg::ARG_BYTES;
            endcase
         end
      end
      return o;
   endfunction

   // Feed one word character to the number or mnemonic matcher
   function automatic ssa_pkg::parse_state_type take_char(ssa_pkg::parse_state_type s,
                                                          logic [7:0] c, logic digit);
      ssa_pkg::parse_state_type o;
      logic [35:0]              grown;
      o     = s;
      grown = ({4'd0, s.number_value} << 3) + ({4'd0, s.number_value} << 1)
              + {32'd0, c[3:0]};
      if (s.pending_argument == ssa_pkg::ARG_BYTES) begin
         o = s;
      end else if (s.word_is_number) begin
         if (!s.number_stopped) begin
            if (digit) begin
               o.number_value = (|grown[35:32]) ? 32'hffff_ffff : grown[31:0];
            end else begin
               o.number_stopped = 1'b1;
            end
         end
      end else if (s.word_position >= MAX_LEN) begin
         o.mnemonic_candidates = 4'd0;
      end else begin
         for (int k = 0; k < 4; k++) begin
            if (!(s.word_position < ssa_pkg::MN_LEN[k]
                  && ssa_pkg::MN_TEXT[k][s.word_position[2:0]] == c)) begin
               o.mnemonic_candidates[k] = 1'b0;
            end
         end
         o.word_position = s.word_position + 1'b1;
      end
      return o;
   endfunction

   assign is_digit = (source_byte >= ssa_pkg::CHAR_ZERO) && (source_byte <= ssa_pkg::CHAR_NINE);
   assign is_separator = (source_byte == ssa_pkg::CHAR_SPACE)
                      || (source_byte == ssa_pkg::CHAR_NEWLINE)
                      || (source_byte == ssa_pkg::CHAR_SEMICOLON)
                      || (source_byte == ssa_pkg::CHAR_QUOTE);

   // Process one source byte against the current parse state
   always_comb begin
      work.st = state_ff;
      work.rs = '0;
      if (!state_ff.halted) begin
         if (state_ff.in_comment) begin
            if (source_byte == ssa_pkg::CHAR_NEWLINE) work.st.in_comment = 1'b0;
         end else if (state_ff.in_string) begin
            if (source_byte == ssa_pkg::CHAR_QUOTE) begin
               work.st.in_string = 1'b0;
               if (state_ff.pending_argument == ssa_pkg::ARG_BYTES)
                  work.st.pending_argument = ssa_pkg::ARG_NONE;
            end else if (state_ff.pending_argument == ssa_pkg::ARG_BYTES) begin
               work.rs = put_result(work.rs, source_byte, ssa_pkg::ERR_NONE);
            end
         end else if (is_separator) begin
            if (state_ff.in_word) work = finish_word(work);
            if (!work.st.halted) begin
               if (source_byte == ssa_pkg::CHAR_SEMICOLON) begin
                  work.st.in_comment = 1'b1;
               end else if (source_byte == ssa_pkg::CHAR_QUOTE) begin
                  if (work.st.pending_argument == ssa_pkg::ARG_PUSH) begin
                     work.rs        = put_result(work.rs, 8'h00, ssa_pkg::ERR_ARG_TYPE);
                     work.st.halted = 1'b1;
                  end else begin
                     work.st.in_string = 1'b1;
                  end
               end
            end
         end else begin
            if (!state_ff.in_word) begin
               work.st.in_word             = 1'b1;
               work.st.word_position       = '0;
               work.st.mnemonic_candidates = 4'hf;
               work.st.word_is_number      = is_digit;
               work.st.number_stopped      = 1'b0;
               work.st.number_value        = 32'd0;
               if (state_ff.pending_argument == ssa_pkg::ARG_PUSH && !is_digit) begin
                  work.rs        = put_result(work.rs, 8'h00, ssa_pkg::ERR_ARG_TYPE);
                  work.st.halted = 1'b1;
               end
            end
            if (!work.st.halted) begin
               if (work.st.pending_argument == ssa_pkg::ARG_BYTES)
                  work.rs = put_result(work.rs, source_byte, ssa_pkg::ERR_NONE);
               work.st = take_char(work.st, source_byte, is_digit);
            end
         end

         // Close out the source on its last byte
         if (end_of_source && !work.st.halted) begin
            if (work.st.in_word) work = finish_word(work);
            if (!work.st.halted) begin
               if (work.st.in_string && work.st.pending_argument == ssa_pkg::ARG_BYTES)
                  work.st.pending_argument = ssa_pkg::ARG_NONE;
               if (work.st.pending_argument != ssa_pkg::ARG_NONE) begin
                  work.rs        = put_result(work.rs, 8'h00, ssa_pkg::ERR_MISSING);
                  work.st.halted = 1'b1;
               end else begin
                  work.st = ssa_pkg::PARSE_RESET;
               end
            end
         end
      end
   end

   assign state_in = advance ? work.st : state_ff;
   assign rsp_set  = work.rs;

   // Hold parse state between source bytes
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ssa_pkg::PARSE_RESET;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: design/ssa_rsp_buffer.sv
`timescale 1ns / 1ps

module ssa_rsp_buffer (
   input  logic                  clock,
   input  logic                  reset,
   input  ssa_pkg::buf_load_type load,
   output logic                  load_ok,
   ssa_rsp_if.source             rsp
);

   logic [2:0]                              count_ff, count_in;
   logic [1:0]                              rd_ff, rd_in;
   logic [ssa_pkg::MAX_RESULTS-1:0][7:0]    code_ff;
   logic [ssa_pkg::MAX_RESULTS-1:0][1:0]    err_ff;
   logic                                    take;
   logic                                    last_entry;
   logic                                    do_load;

   assign last_entry = ({1'b0, rd_ff} + 3'd1) == count_ff;
   assign take       = rsp.valid && rsp.ready;
   assign load_ok    = (count_ff == 3'd0) || (take && last_entry);
   assign do_load    = load_ok && load.valid;

   // Advance the read pointer, then refill from the parser
   always_comb begin
      count_in = count_ff;
      rd_in    = rd_ff;
      if (take) begin
         if (last_entry) begin
            count_in = 3'd0;
            rd_in    = 2'd0;
         end else begin
            rd_in = rd_ff + 2'd1;
         end
      end
      if (do_load) begin
         count_in = load.set.count;
         rd_in    = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 3'd0;
         rd_ff    <= 2'd0;
      end else begin
         count_ff <= count_in;
         rd_ff    <= rd_in;
      end
   end

   // Capture result payload
   always_ff @(posedge clock) begin
      if (do_load) begin
         code_ff <= load.set.code;
         err_ff  <= load.set.err;
      end
   end

   // Present the current entry
   assign rsp.valid      = count_ff != 3'd0;
   assign rsp.code_byte  = code_ff[rd_ff];
   assign rsp.error_code = err_ff[rd_ff];
   assign rsp.run_last   = last_entry;

endmodule

// File: design/streaming_source_assembler_unit.sv
`timescale 1ns / 1ps

// Streaming assembler: takes source text one byte per transaction and returns
// bytecode bytes, each with an error code and a run_last flag on the final
// result of its source byte. A byte is registered on entry, parsed from that
// register and its results (zero to four) land in a four-entry result register
// that drains one transaction per cycle while the receiver is ready, so plain
// text streams at one byte per cycle while results are taken; a byte yielding
// several results holds the input until its last result is taken, which is
// what a completed push argument (four big-endian bytes) costs. After an error
// result the unit returns nothing more until reset. Mnemonics longer than
// MAX_MNEMONIC_LENGTH never match.
module streaming_source_assembler_unit #(
   parameter int unsigned MAX_MNEMONIC_LENGTH = 8
) (
   input  logic      clock,
   input  logic      reset,
   ssa_req_if.sink   req_channel,
   ssa_rsp_if.source rsp_channel
);

   logic                  in_valid_ff, in_valid_in;
   logic [7:0]            in_byte_ff;
   logic                  in_eos_ff;
   logic                  accept;
   logic                  advance;
   logic                  load_ok;
   ssa_pkg::rsp_set_type  rsp_set;
   ssa_pkg::buf_load_type buf_load;

   // Input register: refill whenever it empties or is consumed
   assign advance           = in_valid_ff && load_ok;
   assign req_channel.ready = !in_valid_ff || advance;
   assign accept            = req_channel.valid && req_channel.ready;
   assign in_valid_in       = accept || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= req_channel.source_byte;
         in_eos_ff  <= req_channel.end_of_source;
      end
   end

   ssa_parse #(
      .MAX_MNEMONIC_LENGTH(MAX_MNEMONIC_LENGTH)
   ) u_parse (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .source_byte  (in_byte_ff),
      .end_of_source(in_eos_ff),
      .rsp_set      (rsp_set)
   );

   // Load only bytes that produced results
   assign buf_load.valid = advance && (rsp_set.count != 3'd0);
   assign buf_load.set   = rsp_set;

   ssa_rsp_buffer u_rsp_buffer (
      .clock  (clock),
      .reset  (reset),
      .load   (buf_load),
      .load_ok(load_ok),
      .rsp    (rsp_channel)
   );

endmodule

// File: design/ssa_checker.sv
`timescale 1ns / 1ps
`include "streaming_source_assembler_unit_defines.svh"

module ssa_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_code_byte,
   input logic [1:0] rsp_error_code,
   input logic       rsp_run_last
);

   // Hold a stalled result
   `SSA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_code_byte) && $stable(rsp_error_code) && $stable(rsp_run_last), "stalled result changed")

   // Error results carry a zero byte and close their run
   `SSA_ASSERT_IMPLY(a_err_shape, clock, reset, rsp_valid && rsp_error_code != ssa_pkg::ERR_NONE, rsp_code_byte == 8'h00 && rsp_run_last, "malformed error result")

   // Nothing follows a taken error result
   `SSA_ASSERT_NEXT(a_err_halts, clock, reset, rsp_valid && rsp_ready && rsp_error_code != ssa_pkg::ERR_NONE, !rsp_valid, "result after error")

   // A run continues until its last result
   `SSA_ASSERT_NEXT(a_run_continues, clock, reset, rsp_valid && rsp_ready && !rsp_run_last, rsp_valid, "run broken before last result")

endmodule

bind streaming_source_assembler_unit ssa_checker u_ssa_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_channel.valid),
   .rsp_ready     (rsp_channel.ready),
   .rsp_code_byte (rsp_channel.code_byte),
   .rsp_error_code(rsp_channel.error_code),
   .rsp_run_last  (rsp_channel.run_last)
);

// File: bench/streaming_source_assembler_unit_tb.sv
`timescale 1ns / 1ps

module streaming_source_assembler_unit_tb;

   localparam int CLOCK_PERIOD   = 8;
   localparam int RESET_CYCLES   = 6;
   localparam int MNEMONIC_LIMIT = 8;
   localparam int SETTLE_CYCLES  = 8;
   localparam int TIME_LIMIT_NS  = 6_000_000;

   // Parser state tracked alongside the unit
   typedef struct packed {
      logic        in_string;
      logic        in_comment;
      logic        in_word;
      logic        word_is_number;
      logic        number_stopped;
      logic [3:0]  word_pos;
      logic [3:0]  cands;
      logic [31:0] value;
      logic [1:0]  pending;
      logic        halted;
   } source_state_type;

   typedef struct packed {
      logic [7:0] code;
      logic [1:0] err;
      logic       last;
   } code_item_type;

   typedef struct packed {
      logic [2:0]            count;
      code_item_type [3:0]   r;
   } code_group_type;

   typedef struct packed {
      source_state_type st;
      code_group_type   g;
   } byte_outcome_type;

   logic clock = 1'b0;
   logic reset;

   ssa_req_if req_bus ();
   ssa_rsp_if rsp_bus ();

   streaming_source_assembler_unit #(
      .MAX_MNEMONIC_LENGTH(MNEMONIC_LIMIT)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_channel(req_bus),
      .rsp_channel(rsp_bus)
   );

   source_state_type source_state;
   code_item_type    expected_codes[$];
   logic [8:0]       token_bytes[$];
   int               mismatches;
   int               bytes_sent;
   bit               steady_stream;

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // ---------------------------------------------------------------------
   // Byte-level parser model
   // ---------------------------------------------------------------------

   // Spell a mnemonic from the shared table
   function automatic string mnemonic_text(int k);
      string s;
      int    i;
      s = "";
      for (i = 0; i < int'(ssa_pkg::MN_LEN[k]); i++)
         s = $sformatf("%s%c", s, ssa_pkg::MN_TEXT[k][i]);
      return s;
   endfunction

   function automatic bit is_digit(logic [7:0] c);
      return (c >= ssa_pkg::CHAR_ZERO) && (c <= ssa_pkg::CHAR_NINE);
   endfunction

   function automatic bit is_separator(logic [7:0] c);
      return (c == ssa_pkg::CHAR_SPACE) || (c == ssa_pkg::CHAR_NEWLINE) ||
             (c == ssa_pkg::CHAR_SEMICOLON) || (c == ssa_pkg::CHAR_QUOTE);
   endfunction

   function automatic source_state_type idle_state();
      source_state_type s;
      s = '0;
      s.cands = 4'hf;
      s.pending = ssa_pkg::ARG_NONE;
      return s;
   endfunction

   function automatic byte_outcome_type add_result(byte_outcome_type o, logic [7:0] code,
                                                   logic [1:0] err);
      code_item_type item;
      if (o.g.count < 3'd4) begin
         item.code = code;
         item.err = err;
         item.last = 1'b0;
         o.g.r[o.g.count[1:0]] = item;
         o.g.count = o.g.count + 3'd1;
      end
      return o;
   endfunction

   function automatic byte_outcome_type fail_with(byte_outcome_type o, logic [1:0] err);
      o = add_result(o, 8'h00, err);
      o.st.halted = 1'b1;
      return o;
   endfunction

   // Fold one word character into the number or the mnemonic match
   function automatic source_state_type take_char(source_state_type s, logic [7:0] c);
      logic [63:0] wide;
      string       name;
      int          k;
      if (s.pending != ssa_pkg::ARG_BYTES) begin
         if (s.word_is_number) begin
            if (!s.number_stopped) begin
               if (is_digit(c)) begin
                  wide = {32'd0, s.value} * 64'd10 + {56'd0, c - ssa_pkg::CHAR_ZERO};
                  s.value = (wide > 64'h0000_0000_ffff_ffff) ? 32'hffff_ffff : wide[31:0];
               end else begin
                  s.number_stopped = 1'b1;
               end
            end
         end else if (s.word_pos >= MNEMONIC_LIMIT) begin
            s.cands = 4'h0;
         end else begin
            for (k = 0; k < 4; k++) begin
               name = mnemonic_text(k);
               if (!((s.word_pos < name.len()) && (name[s.word_pos] == c)))
                  s.cands[k] = 1'b0;
            end
            s.word_pos = s.word_pos + 4'd1;
         end
      end
      return s;
   endfunction

   // Close the current word: emit a push argument or classify a mnemonic
   function automatic byte_outcome_type finish_word(byte_outcome_type o);
      logic [1:0] pend;
      logic [1:0] hit;
      bit         found;
      string      name;
      int         k;
      pend = o.st.pending;
      o.st.in_word = 1'b0;
      o.st.pending = ssa_pkg::ARG_NONE;
      if (pend == ssa_pkg::ARG_PUSH) begin
         o = add_result(o, o.st.value[31:24], ssa_pkg::ERR_NONE);
         o = add_result(o, o.st.value[23:16], ssa_pkg::ERR_NONE);
         o = add_result(o, o.st.value[15:8], ssa_pkg::ERR_NONE);
         o = add_result(o, o.st.value[7:0], ssa_pkg::ERR_NONE);
      end else if ((pend == ssa_pkg::ARG_NONE) && !o.st.word_is_number) begin
         found = 1'b0;
         hit = ssa_pkg::MN_SYSCALL;
         for (k = 0; k < 4; k++) begin
            name = mnemonic_text(k);
            if (o.st.cands[k] && (o.st.word_pos == name.len())) begin
               found = 1'b1;
               hit = 2'(k);
            end
         end
         if (!found) begin
            o = fail_with(o, ssa_pkg::ERR_UNKNOWN);
         end else begin
            case (hit)
               ssa_pkg::MN_SYSCALL: o = add_result(o, ssa_pkg::OP_SYSCALL, ssa_pkg::ERR_NONE);
               ssa_pkg::MN_ADD32:   o = add_result(o, ssa_pkg::OP_ADD32, ssa_pkg::ERR_NONE);
               ssa_pkg::MN_PUSH: begin
                  o = add_result(o, ssa_pkg::OP_PUSH, ssa_pkg::ERR_NONE);
                  o.st.pending = ssa_pkg::ARG_PUSH;
               end
               default:     o.st.pending = ssa_pkg::ARG_BYTES;
            endcase
         end
      end
      return o;
   endfunction

   // Predict the code bytes caused by one source byte
   function automatic byte_outcome_type assemble_byte(source_state_type s, logic [7:0] c,
                                                      logic eos);
      byte_outcome_type o;
      code_item_type    tail;
      o.st = s;
      o.g = '0;
      if (!s.halted) begin
         if (o.st.in_comment) begin
            if (c == ssa_pkg::CHAR_NEWLINE) o.st.in_comment = 1'b0;
         end else if (o.st.in_string) begin
            if (c == ssa_pkg::CHAR_QUOTE) begin
               o.st.in_string = 1'b0;
               if (o.st.pending == ssa_pkg::ARG_BYTES) o.st.pending = ssa_pkg::ARG_NONE;
            end else if (o.st.pending == ssa_pkg::ARG_BYTES) begin
               o = add_result(o, c, ssa_pkg::ERR_NONE);
            end
         end else if (is_separator(c)) begin
            if (o.st.in_word) o = finish_word(o);
            if (!o.st.halted) begin
               if (c == ssa_pkg::CHAR_SEMICOLON) begin
                  o.st.in_comment = 1'b1;
               end else if (c == ssa_pkg::CHAR_QUOTE) begin
                  if (o.st.pending == ssa_pkg::ARG_PUSH) o = fail_with(o, ssa_pkg::ERR_ARG_TYPE);
                  else o.st.in_string = 1'b1;
               end
            end
         end else begin
            if (!o.st.in_word) begin
               o.st.in_word = 1'b1;
               o.st.word_pos = 4'd0;
               o.st.cands = 4'hf;
               o.st.word_is_number = is_digit(c);
               o.st.number_stopped = 1'b0;
               o.st.value = 32'd0;
               if ((o.st.pending == ssa_pkg::ARG_PUSH) && !o.st.word_is_number)
                  o = fail_with(o, ssa_pkg::ERR_ARG_TYPE);
            end
            if (!o.st.halted) begin
               if (o.st.pending == ssa_pkg::ARG_BYTES) o = add_result(o, c, ssa_pkg::ERR_NONE);
               o.st = take_char(o.st, c);
            end
         end

         // End of source: close the word and any string, then start over unless an argument is missing
         if (eos && !o.st.halted) begin
            if (o.st.in_word) o = finish_word(o);
            if (!o.st.halted) begin
               if (o.st.in_string && (o.st.pending == ssa_pkg::ARG_BYTES))
                  o.st.pending = ssa_pkg::ARG_NONE;
               if (o.st.pending != ssa_pkg::ARG_NONE) o = fail_with(o, ssa_pkg::ERR_MISSING);
               else o.st = idle_state();
            end
         end

         if (o.g.count > 3'd0) begin
            tail = o.g.r[o.g.count[1:0] - 2'd1];
            tail.last = 1'b1;
            o.g.r[o.g.count[1:0] - 2'd1] = tail;
         end
      end
      return o;
   endfunction

   // ---------------------------------------------------------------------
   // Channel drivers and result checker
   // ---------------------------------------------------------------------

   function automatic int idle_length(bit allow_zero);
      int roll;
      roll = $urandom_range(0, 99);
      if (steady_stream) return allow_zero ? 0 : 1;
      if (allow_zero && (roll < 60)) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 8);
      return $urandom_range(12, 40);
   endfunction

   // Send one source byte and record its predicted code bytes on acceptance
   task automatic send_byte(input logic [7:0] c, input logic eos);
      byte_outcome_type outcome;
      int               gap;
      int               i;
      gap = idle_length(1'b1);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.source_byte <= c;
      req_bus.end_of_source <= eos;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      outcome = assemble_byte(source_state, c, eos);
      source_state = outcome.st;
      for (i = 0; i < outcome.g.count; i++) expected_codes.push_back(outcome.g.r[i]);
      bytes_sent++;
   endtask

   task automatic send_text(input string s, input bit eos_at_end);
      int i;
      for (i = 0; i < s.len(); i++) send_byte(s[i], eos_at_end && (i == s.len() - 1));
   endtask

   // Hold off the sender until every predicted code byte has come back
   task automatic wait_for_results();
      req_bus.valid <= 1'b0;
      while (expected_codes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Stall the result side at random, except in steady streaming
   initial begin : drive_result_ready
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (!steady_stream && ($urandom_range(0, 4) == 0)) begin
            rsp_bus.ready <= 1'b0;
            repeat (idle_length(1'b0)) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   end

   // Compare each result transaction with the oldest prediction
   always @(posedge clock) begin : check_results
      code_item_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_codes.size() == 0) begin
            $display("%0t: unexpected result code_byte=%h error_code=%0d run_last=%b",
                     $time, rsp_bus.code_byte, rsp_bus.error_code, rsp_bus.run_last);
            mismatches++;
         end else begin
            want = expected_codes.pop_front();
            if (rsp_bus.code_byte !== want.code) begin
               $display("%0t: code_byte expected %h actual %h", $time, want.code,
                        rsp_bus.code_byte);
               mismatches++;
            end
            if (rsp_bus.error_code !== want.err) begin
               $display("%0t: error_code expected %0d actual %0d", $time, want.err,
                        rsp_bus.error_code);
               mismatches++;
            end
            if (rsp_bus.run_last !== want.last) begin
               $display("%0t: run_last expected %b actual %b", $time, want.last,
                        rsp_bus.run_last);
               mismatches++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Random source tokens
   // ---------------------------------------------------------------------

   function automatic logic [7:0] word_char();
      logic [7:0] c;
      c = 8'($urandom_range(0, 255));
      while (is_separator(c)) c = 8'($urandom_range(0, 255));
      return c;
   endfunction

   task automatic add_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++) token_bytes.push_back({1'b0, s[i]});
   endtask

   task automatic add_separator();
      token_bytes.push_back({1'b0, ($urandom_range(0, 2) == 0) ? ssa_pkg::CHAR_NEWLINE
                                                                : ssa_pkg::CHAR_SPACE});
   endtask

   task automatic add_number();
      int i;
      int digits;
      digits = $urandom_range(1, 12);
      for (i = 0; i < digits; i++)
         token_bytes.push_back({1'b0, ssa_pkg::CHAR_ZERO + 8'($urandom_range(0, 9))});
      // Sometimes stop the number with trailing junk
      if ($urandom_range(0, 3) == 0) begin
         token_bytes.push_back({1'b0, 8'h61 + 8'($urandom_range(0, 25))});
         repeat ($urandom_range(0, 3)) token_bytes.push_back({1'b0, word_char()});
      end
   endtask

   task automatic add_string();
      logic [7:0] c;
      token_bytes.push_back({1'b0, ssa_pkg::CHAR_QUOTE});
      repeat ($urandom_range(0, 8)) begin
         c = 8'($urandom_range(0, 255));
         while (c == ssa_pkg::CHAR_QUOTE) c = 8'($urandom_range(0, 255));
         token_bytes.push_back({1'b0, c});
      end
      token_bytes.push_back({1'b0, ssa_pkg::CHAR_QUOTE});
   endtask

   task automatic build_token();
      int         kind;
      logic [7:0] c;
      token_bytes.delete();
      kind = $urandom_range(0, 99);
      if (kind < 12) begin
         add_text("syscall");
         add_separator();
      end else if (kind < 22) begin
         add_text(mnemonic_text(ssa_pkg::MN_ADD32));
         add_separator();
      end else if (kind < 42) begin
         add_text("push ");
         add_number();
         add_separator();
      end else if (kind < 56) begin
         add_text("bytes ");
         add_string();
         add_separator();
      end else if (kind < 62) begin
         add_text("bytes ");
         repeat ($urandom_range(1, 10)) token_bytes.push_back({1'b0, word_char()});
         add_separator();
      end else if (kind < 68) begin
         token_bytes.push_back({1'b0, ssa_pkg::CHAR_SEMICOLON});
         repeat ($urandom_range(0, 10)) begin
            c = 8'($urandom_range(0, 255));
            while (c == ssa_pkg::CHAR_NEWLINE) c = 8'($urandom_range(0, 255));
            token_bytes.push_back({1'b0, c});
         end
         token_bytes.push_back({1'b0, ssa_pkg::CHAR_NEWLINE});
      end else if (kind < 72) begin
         add_string();
         add_separator();
      end else if (kind < 76) begin
         add_number();
         add_separator();
      end else if (kind < 80) begin
         repeat ($urandom_range(1, 3)) add_separator();
      end else begin
         repeat ($urandom_range(1, 6)) token_bytes.push_back({1'b0, 8'($urandom_range(0, 255))});
      end
      if ($urandom_range(0, 11) == 0) token_bytes[token_bytes.size() - 1][8] = 1'b1;
   endtask

   // Accept a token only if it and a following space leave the unit running
   function automatic bit token_is_safe();
      source_state_type s;
      byte_outcome_type o;
      int               i;
      s = source_state;
      for (i = 0; i < token_bytes.size(); i++) begin
         o = assemble_byte(s, token_bytes[i][7:0], token_bytes[i][8]);
         s = o.st;
      end
      o = assemble_byte(s, ssa_pkg::CHAR_SPACE, 1'b0);
      return !o.st.halted;
   endfunction

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   task automatic test_plain_opcodes();
      send_text({"syscall ", mnemonic_text(ssa_pkg::MN_ADD32), "\nsyscall\n"}, 1'b0);
   endtask

   task automatic test_push_numbers();
      // Zero, the largest value, saturation and a number cut short
      send_text("push 0 push 4294967295\npush 4294967296 push 99999999999999 ", 1'b0);
      send_text("push 12ab34 push 007;c\n", 1'b0);
   endtask

   task automatic test_bytes_arguments();
      send_text("bytes \"Hi x\" bytes word bytes \"\" bytes \"", 1'b0);
      // Zero and all-ones bytes inside a string
      send_byte(8'h00, 1'b0);
      send_byte(8'hff, 1'b0);
      send_text("\" bytes a", 1'b0);
      // Tab, carriage return and zero as plain word characters
      send_byte(8'h09, 1'b0);
      send_byte(8'h0d, 1'b0);
      send_byte(8'h00, 1'b0);
      send_text({" bytes ", mnemonic_text(ssa_pkg::MN_ADD32), "push\nbytes\n\"z\" bytes x\"y\" "},
                1'b0);
   endtask

   task automatic test_separators_and_comments();
      send_text("; push 1 \"\nsyscall\"stray string\" 123 9abc syscall;x\n", 1'b0);
   endtask

   task automatic test_end_of_source();
      send_text("syscall", 1'b1);
      send_text("push 42", 1'b1);
      send_text("bytes \"open", 1'b1);
      send_text("; open comment", 1'b1);
      send_text({mnemonic_text(ssa_pkg::MN_ADD32), " "}, 1'b1);
   endtask

   task automatic test_random_stream(input int byte_count);
      int start;
      int tries;
      start = bytes_sent;
      while (bytes_sent - start < byte_count) begin
         tries = 0;
         build_token();
         while (!token_is_safe() && (tries < 40)) begin
            build_token();
            tries++;
         end
         if (!token_is_safe()) begin
            token_bytes.delete();
            token_bytes.push_back({1'b0, ssa_pkg::CHAR_SPACE});
         end
         while (token_bytes.size() != 0) begin
            send_byte(token_bytes[0][7:0], token_bytes[0][8]);
            void'(token_bytes.pop_front());
         end
      end
   endtask

   // Bring the parser back to a clean source boundary
   task automatic settle_source();
      if (source_state.in_word) send_byte(ssa_pkg::CHAR_SPACE, 1'b0);
      if (source_state.in_comment) send_byte(ssa_pkg::CHAR_NEWLINE, 1'b0);
      if (source_state.in_string) send_byte(ssa_pkg::CHAR_QUOTE, 1'b0);
      if (source_state.pending == ssa_pkg::ARG_PUSH) send_text("0 ", 1'b0);
      if (source_state.pending == ssa_pkg::ARG_BYTES) send_text("x ", 1'b0);
      send_byte(ssa_pkg::CHAR_SPACE, 1'b1);
   endtask

   // One error halts the unit for the rest of the run
   task automatic test_error_halt();
      int pick;
      settle_source();
      pick = $urandom_range(0, 6);
      case (pick)
         0: send_text("sycsall ", 1'b0);
         1: send_text({mnemonic_text(ssa_pkg::MN_ADD32), "d "}, 1'b0);
         2: send_text("push abc ", 1'b0);
         3: send_text("push \"x\" ", 1'b0);
         4: send_text("push", 1'b1);
         5: send_text("bytes\n", 1'b1);
         default: send_text("syscallsyscall\n", 1'b0);
      endcase
      // Nothing more comes back once halted
      send_text("syscall push 1\n", 1'b1);
   endtask

   initial begin : run_tests
      mismatches = 0;
      bytes_sent = 0;
      steady_stream = 1'b0;
      source_state = idle_state();
      req_bus.valid <= 1'b0;
      req_bus.source_byte <= 8'h00;
      req_bus.end_of_source <= 1'b0;
      reset <= 1'b1;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_plain_opcodes();
      test_push_numbers();
      test_bytes_arguments();
      test_separators_and_comments();
      test_end_of_source();
      wait_for_results();
      test_random_stream(40);
      wait_for_results();
      test_random_stream(40);
      steady_stream = 1'b1;
      test_random_stream(30);
      steady_stream = 1'b0;
      wait_for_results();
      test_error_halt();
      wait_for_results();

      if (expected_codes.size() != 0) begin
         $display("%0t: %0d predicted code bytes never arrived", $time, expected_codes.size());
         mismatches++;
      end
      if (mismatches == 0) begin
         $display("streaming_source_assembler_unit_tb: PASS");
      end else begin
         $display("streaming_source_assembler_unit_tb: FAIL");
      end
      $finish;
   end

   initial begin : watchdog
      #(TIME_LIMIT_NS);
      $display("streaming_source_assembler_unit_tb: FAIL");
      $finish;
   end

endmodule
